>>> rtl/uitp_pkg.sv
`default_nettype none

package uitp_pkg;

   localparam int VALUE_PORT_BITS  = 64;
   localparam int OFFSET_PORT_BITS = 16;
   localparam int RADIX_BITS       = 6;
   localparam int DIGIT_BITS       = 6;

   localparam int VALUE_BITS_DEF  = 64;
   localparam int OFFSET_BITS_DEF = 16;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [OFFSET_PORT_BITS-1:0] OFFSET_SAT = '1;

   localparam logic [RADIX_BITS-1:0] RADIX_AUTO = 6'd0;
   localparam logic [RADIX_BITS-1:0] RADIX_MIN  = 6'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_OCT  = 6'd8;
   localparam logic [RADIX_BITS-1:0] RADIX_DEC  = 6'd10;
   localparam logic [RADIX_BITS-1:0] RADIX_HEX  = 6'd16;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX  = 6'd36;

   localparam logic [DIGIT_BITS-1:0] DIG_NONE = '1;

   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_DIG0    = 8'h30;
   localparam logic [7:0] CH_DIG9    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_UPPER_X = 8'h58;
   localparam logic [7:0] CH_LOWER_X = 8'h78;
   localparam logic [7:0] CH_UPPER_BASE = CH_UPPER_A - 8'd10;
   localparam logic [7:0] CH_LOWER_BASE = CH_LOWER_A - 8'd10;

   typedef enum logic [2:0] {
      PH_WS,
      PH_SIGN,
      PH_ZERO,
      PH_XPEND,
      PH_DIGITS,
      PH_DONE
   } uitp_phase_type;

   typedef struct packed {
      logic [7:0]            ch;
      logic                  start_req;
      logic [RADIX_BITS-1:0] radix;
   } uitp_req_type;

   typedef struct packed {
      logic [VALUE_PORT_BITS-1:0]  value;
      logic [OFFSET_PORT_BITS-1:0] end_offset;
      logic                        done_res;
      logic                        overflow;
   } uitp_rsp_type;

   // classified character as it waits in the queue
   typedef struct packed {
      logic                  start;
      logic [RADIX_BITS-1:0] radix;
      logic                  is_space;
      logic                  is_sign;
      logic                  is_minus;
      logic                  is_zero;
      logic                  is_x;
      logic [DIGIT_BITS-1:0] dig;
   } uitp_item_type;

   typedef struct packed {
      logic                 full;
      logic                 empty;
      logic [QCNT_BITS-1:0] count;
   } uitp_qstat_type;

endpackage

`default_nettype wire

>>> rtl/uitp_front.sv
`default_nettype none

module uitp_front (
   input  logic                     req_valid,
   output logic                     req_ready,
   input  uitp_pkg::uitp_req_type   req_payload,
   input  uitp_pkg::uitp_qstat_type qstat,
   output logic                     push,
   output uitp_pkg::uitp_item_type  item
);
   import uitp_pkg::*;

   logic [7:0] ch;

   assign ch        = req_payload.ch;
   assign req_ready = !qstat.full;
   assign push      = req_valid && req_ready;

   always_comb begin
      item.start    = req_payload.start_req;
      item.radix    = req_payload.radix;
      item.is_space = (ch == CH_SPACE) || (ch inside {[CH_TAB:CH_CR]});
      item.is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
      item.is_minus = (ch == CH_MINUS);
      item.is_zero  = (ch == CH_DIG0);
      item.is_x     = (ch == CH_LOWER_X) || (ch == CH_UPPER_X);
      if (ch inside {[CH_DIG0:CH_DIG9]}) begin
         item.dig = DIGIT_BITS'(ch - CH_DIG0);
      end else if (ch inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
         item.dig = DIGIT_BITS'(ch - CH_UPPER_BASE);
      end else if (ch inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
         item.dig = DIGIT_BITS'(ch - CH_LOWER_BASE);
      end else begin
         item.dig = DIG_NONE;
      end
   end

endmodule

`default_nettype wire

>>> rtl/uitp_queue.sv
`default_nettype none

module uitp_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  uitp_pkg::uitp_item_type  wr_item,
   input  logic                     pop,
   output uitp_pkg::uitp_item_type  rd_item,
   output uitp_pkg::uitp_qstat_type qstat
);
   import uitp_pkg::*;

   uitp_item_type        slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_BITS'(push) - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_item;
      end
   end

   assign rd_item     = slot_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign qstat.count = count_ff;

endmodule

`default_nettype wire

>>> rtl/uitp_back.sv
`default_nettype none

module uitp_back #(
   parameter int VALUE_BITS  = uitp_pkg::VALUE_BITS_DEF,
   parameter int OFFSET_BITS = uitp_pkg::OFFSET_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  uitp_pkg::uitp_item_type  head,
   input  uitp_pkg::uitp_qstat_type qstat,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output uitp_pkg::uitp_rsp_type   rsp_payload
);
   import uitp_pkg::*;

   localparam int MAC_BITS = VALUE_BITS + RADIX_BITS + 1;
   localparam int END_W    = (OFFSET_BITS > OFFSET_PORT_BITS) ? OFFSET_BITS : OFFSET_PORT_BITS;

   uitp_phase_type          phase_ff, phase_in, cur_phase, tk_phase;
   logic [RADIX_BITS-1:0]   radix_ff, radix_in, cur_radix, tr;
   logic [VALUE_BITS-1:0]   acc_ff, acc_in, cur_acc, tk_acc;
   logic                    neg_ff, neg_in, cur_neg;
   logic                    ovf_ff, ovf_in, cur_ovf, tk_ovf;
   logic [OFFSET_BITS-1:0]  pos_ff, pos_in, cur_pos, npos;
   logic [OFFSET_BITS-1:0]  end_ff, end_in, cur_end, tk_end;
   logic                    out_valid_ff, out_valid_in;
   logic [MAC_BITS-1:0]     mac;
   logic                    mac_ovf, dig_ok, first_zero;
   logic [VALUE_BITS-1:0]   neg_acc, value_w;
   logic [END_W-1:0]        end_w;

   assign pop          = !qstat.empty && (!out_valid_ff || rsp_ready);
   assign out_valid_in = pop || (out_valid_ff && !rsp_ready);

   always_comb begin
      cur_phase = phase_ff;
      cur_radix = radix_ff;
      cur_acc   = acc_ff;
      cur_neg   = neg_ff;
      cur_ovf   = ovf_ff;
      cur_pos   = pos_ff;
      cur_end   = end_ff;
      // a start beat restarts the parser before its own character is seen
      if (head.start) begin
         cur_phase = PH_WS;
         cur_radix = head.radix;
         cur_acc   = '0;
         cur_neg   = 1'b0;
         cur_ovf   = 1'b0;
         cur_pos   = '0;
         cur_end   = '0;
      end

      npos = (&cur_pos) ? cur_pos : cur_pos + 1'b1;

      case (cur_phase)
         PH_WS, PH_SIGN: tr = (cur_radix == RADIX_AUTO) ? RADIX_DEC : cur_radix;
         PH_ZERO:        tr = (cur_radix == RADIX_AUTO) ? RADIX_OCT : cur_radix;
         default:        tr = cur_radix;
      endcase

      // acc*radix+digit beyond the value width is exactly the saturation case
      mac     = MAC_BITS'(cur_acc) * MAC_BITS'(tr) + MAC_BITS'(head.dig);
      mac_ovf = |mac[MAC_BITS-1:VALUE_BITS];
      dig_ok  = (tr >= RADIX_MIN) && (tr <= RADIX_MAX) && (head.dig < tr);

      tk_phase = dig_ok ? PH_DIGITS : PH_DONE;
      tk_acc   = (dig_ok && !cur_ovf && !mac_ovf) ? mac[VALUE_BITS-1:0] : cur_acc;
      tk_ovf   = cur_ovf || (dig_ok && mac_ovf);
      tk_end   = dig_ok ? npos : cur_end;

      first_zero = head.is_zero && ((cur_radix == RADIX_AUTO) || (cur_radix == RADIX_HEX));

      phase_in = cur_phase;
      radix_in = cur_radix;
      acc_in   = cur_acc;
      neg_in   = cur_neg;
      ovf_in   = cur_ovf;
      end_in   = cur_end;
      pos_in   = (cur_phase == PH_DONE) ? cur_pos : npos;

      case (cur_phase)
         PH_WS, PH_SIGN: begin
            if (cur_phase == PH_WS && head.is_space) begin
               phase_in = PH_WS;
            end else if (cur_phase == PH_WS && head.is_sign) begin
               neg_in   = head.is_minus;
               phase_in = PH_SIGN;
            end else if (first_zero) begin
               acc_in   = '0;
               end_in   = npos;
               phase_in = PH_ZERO;
            end else begin
               phase_in = tk_phase;
               radix_in = tr;
               acc_in   = tk_acc;
               ovf_in   = tk_ovf;
               end_in   = tk_end;
            end
         end
         PH_ZERO: begin
            if (head.is_x) begin
               radix_in = RADIX_HEX;
               phase_in = PH_XPEND;
            end else begin
               phase_in = tk_phase;
               radix_in = tr;
               acc_in   = tk_acc;
               ovf_in   = tk_ovf;
               end_in   = tk_end;
            end
         end
         PH_XPEND, PH_DIGITS: begin
            // a prefix with no hex digit after it leaves the lone zero
            if (cur_phase == PH_XPEND && !(head.dig < RADIX_HEX)) begin
               phase_in = PH_DONE;
            end else begin
               phase_in = tk_phase;
               acc_in   = tk_acc;
               ovf_in   = tk_ovf;
               end_in   = tk_end;
            end
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WS;
      end else if (pop) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff     <= '0;
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         pos_ff       <= '0;
         end_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop) begin
            radix_ff <= radix_in;
            acc_ff   <= acc_in;
            neg_ff   <= neg_in;
            ovf_ff   <= ovf_in;
            pos_ff   <= pos_in;
            end_ff   <= end_in;
         end
      end
   end

   // parser state after the last beat is the result itself
   assign neg_acc = ~acc_ff + {{(VALUE_BITS-1){1'b0}}, 1'b1};
   assign value_w = ovf_ff ? '1 : (neg_ff ? neg_acc : acc_ff);
   assign end_w   = END_W'(end_ff);

   assign rsp_valid              = out_valid_ff;
   assign rsp_payload.value      = VALUE_PORT_BITS'(value_w);
   assign rsp_payload.end_offset = (end_w > END_W'(OFFSET_SAT)) ? OFFSET_SAT
                                                                : end_w[OFFSET_PORT_BITS-1:0];
   assign rsp_payload.done_res   = (phase_ff == PH_DONE);
   assign rsp_payload.overflow   = ovf_ff;

endmodule

`default_nettype wire

>>> rtl/unsigned_integer_text_parser_top.sv
`default_nettype none

// channel   dir   handshake                payload
// req_      in    req_valid / req_ready    uitp_req_type: ch, start_req, radix
// rsp_      out   rsp_valid / rsp_ready    uitp_rsp_type: value, end_offset, done_res, overflow
//
// one character per cycle sustained while rsp_ready keeps up; a result is registered in the back end
// after its beat passes through the queue, formed by the single multiply-add and range compare
// a two-entry queue between classifier and parser absorbs short stalls on rsp_
// synchronous active-high reset; parsing after reset runs as a string in base 0

module unsigned_integer_text_parser_top #(
   parameter int VALUE_BITS  = uitp_pkg::VALUE_BITS_DEF,
   parameter int OFFSET_BITS = uitp_pkg::OFFSET_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  uitp_pkg::uitp_req_type req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output uitp_pkg::uitp_rsp_type rsp_payload
);
   import uitp_pkg::*;

   uitp_item_type         wr_item, head;
   uitp_qstat_type        qstat;
   logic                  push, pop;
   logic [VALUE_BITS-1:0] value_max;

   assign value_max = '1;

   uitp_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .qstat       (qstat),
      .push        (push),
      .item        (wr_item)
   );

   uitp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_item (wr_item),
      .pop     (pop),
      .rd_item (head),
      .qstat   (qstat)
   );

   uitp_back #(
      .VALUE_BITS  (VALUE_BITS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .qstat       (qstat),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   a_ovf_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.overflow |-> rsp_payload.value == VALUE_PORT_BITS'(value_max))
      else $error("overflow flagged without saturated value");

   a_queue_count: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> qstat.count == $past(qstat.count) + 1'b1)
      else $error("queue count lost a beat");

   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      pop && !head.start && rsp_payload.done_res |=> rsp_payload.done_res)
      else $error("done cleared without a new string");

endmodule

`default_nettype wire

>>> sim/tb.sv
`default_nettype none

module tb;
   import uitp_pkg::*;

   localparam int unsigned RUN_LIMIT   = 600000;
   localparam int unsigned TAIL_CYCLES = 20;
   localparam int unsigned MAX_REPORTS = 100;

   typedef enum logic [1:0] {
      NUM_EMPTY,
      NUM_OK,
      NUM_SAT
   } num_state_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   uitp_req_type req_payload = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   uitp_rsp_type rsp_payload;

   unsigned_integer_text_parser_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // parser state as the block should hold it
   uitp_phase_type               ps_phase;
   logic [VALUE_PORT_BITS-1:0]   ps_acc;
   logic [RADIX_BITS-1:0]        ps_base;
   logic                         ps_neg;
   num_state_type                ps_digits;
   logic [OFFSET_PORT_BITS-1:0]  ps_pos;
   logic [OFFSET_PORT_BITS-1:0]  ps_end;

   uitp_rsp_type pending_results[$];
   int unsigned  fail_count = 0;
   int unsigned  cycle_count = 0;
   int unsigned  send_idle_pct = 36;
   int unsigned  rcv_idle_pct = 57;
   int unsigned  hold_left = 0;

   initial forever #4 clock = ~clock;

   function automatic void clear_parser();
      ps_phase  = PH_WS;
      ps_acc    = '0;
      ps_base   = RADIX_AUTO;
      ps_neg    = 1'b0;
      ps_digits = NUM_EMPTY;
      ps_pos    = '0;
      ps_end    = '0;
   endfunction

   function automatic int unsigned digit_val(logic [7:0] c);
      if (c >= CH_DIG0 && c <= CH_DIG9) return c - CH_DIG0;
      if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return c - CH_UPPER_BASE;
      if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return c - CH_LOWER_BASE;
      return 99;
   endfunction

   function automatic bit is_blank(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic void take_digit(logic [7:0] c, logic [OFFSET_PORT_BITS-1:0] nxt);
      int unsigned                d;
      logic [VALUE_PORT_BITS-1:0] all_ones;
      logic [VALUE_PORT_BITS-1:0] cutoff;
      logic [VALUE_PORT_BITS-1:0] cutlim;
      d = digit_val(c);
      if (ps_base < RADIX_MIN || ps_base > RADIX_MAX || d >= ps_base) begin
         ps_phase = PH_DONE;
         return;
      end
      all_ones = '1;
      cutoff   = all_ones / ps_base;
      cutlim   = all_ones % ps_base;
      if (ps_digits == NUM_SAT || ps_acc > cutoff || (ps_acc == cutoff && d > cutlim)) begin
         ps_digits = NUM_SAT;
      end else begin
         ps_acc    = ps_acc * ps_base + d;
         ps_digits = NUM_OK;
      end
      ps_end   = nxt;
      ps_phase = PH_DIGITS;
   endfunction

   function automatic void first_char(logic [7:0] c, logic [OFFSET_PORT_BITS-1:0] nxt);
      if (c == CH_DIG0 && (ps_base == RADIX_AUTO || ps_base == RADIX_HEX)) begin
         ps_acc    = '0;
         ps_digits = NUM_OK;
         ps_end    = nxt;
         ps_phase  = PH_ZERO;
      end else begin
         if (ps_base == RADIX_AUTO) ps_base = RADIX_DEC;
         take_digit(c, nxt);
      end
   endfunction

   // advance the parser by one character and form the result it reports
   function automatic uitp_rsp_type parse_char(uitp_req_type b);
      logic [OFFSET_PORT_BITS-1:0] nxt;
      uitp_rsp_type                r;
      if (b.start_req) begin
         clear_parser();
         ps_base = b.radix;
      end
      if (ps_phase != PH_DONE) begin
         nxt = (ps_pos != OFFSET_SAT) ? ps_pos + 1'b1 : ps_pos;
         case (ps_phase)
            PH_WS: begin
               if (!is_blank(b.ch)) begin
                  if (b.ch == CH_MINUS || b.ch == CH_PLUS) begin
                     ps_neg   = (b.ch == CH_MINUS);
                     ps_phase = PH_SIGN;
                  end else begin
                     first_char(b.ch, nxt);
                  end
               end
            end
            PH_SIGN: first_char(b.ch, nxt);
            PH_ZERO: begin
               if (b.ch == CH_LOWER_X || b.ch == CH_UPPER_X) begin
                  ps_base  = RADIX_HEX;
                  ps_phase = PH_XPEND;
               end else begin
                  if (ps_base == RADIX_AUTO) ps_base = RADIX_OCT;
                  take_digit(b.ch, nxt);
               end
            end
            PH_XPEND: begin
               if (digit_val(b.ch) < 16) take_digit(b.ch, nxt);
               else ps_phase = PH_DONE;
            end
            default: take_digit(b.ch, nxt);
         endcase
         ps_pos = nxt;
      end
      if (ps_digits == NUM_SAT) r.value = '1;
      else if (ps_neg) r.value = '0 - ps_acc;
      else r.value = ps_acc;
      r.end_offset = ps_end;
      r.done_res   = (ps_phase == PH_DONE);
      r.overflow   = (ps_digits == NUM_SAT);
      return r;
   endfunction

   function automatic uitp_req_type pack_char(logic [7:0] c, logic st, logic [RADIX_BITS-1:0] r);
      uitp_req_type b;
      b.ch        = c;
      b.start_req = st;
      b.radix     = r;
      return b;
   endfunction

   function automatic logic [7:0] digit_char(int unsigned d);
      if (d < 10) return CH_DIG0 + 8'(d);
      return ($urandom_range(1) ? CH_UPPER_BASE : CH_LOWER_BASE) + 8'(d);
   endfunction

   // present one beat, hold it until taken, then log what it should produce
   task automatic send_beat(uitp_req_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(parse_char(b));
   endtask

   // radix on later characters is ignored by the block, so it is left random
   task automatic send_text(string s, logic [RADIX_BITS-1:0] rdx);
      for (int i = 0; i < s.len(); i++)
         send_beat(pack_char(s[i], i == 0, i == 0 ? rdx : RADIX_BITS'($urandom_range(63))));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic note_mismatch(string field, logic [63:0] want, logic [63:0] got);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $error("%s: expected %0h, got %0h", field, want, got);
   endtask

   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      uitp_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) $error("result beat with no expectation waiting");
         end else begin
            want = pending_results.pop_front();
            if (rsp_payload.value !== want.value)
               note_mismatch("value", want.value, rsp_payload.value);
            if (rsp_payload.end_offset !== want.end_offset)
               note_mismatch("end_offset", want.end_offset, rsp_payload.end_offset);
            if (rsp_payload.done_res !== want.done_res)
               note_mismatch("done_res", want.done_res, rsp_payload.done_res);
            if (rsp_payload.overflow !== want.overflow)
               note_mismatch("overflow", want.overflow, rsp_payload.overflow);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= RUN_LIMIT) begin
         $display("** unsigned_integer_text_parser_top: FAILED **");
         $finish;
      end
   end

   // parser runs in auto base when no string was ever started
   task automatic test_no_start();
      send_beat(pack_char("7", 1'b0, 6'd63));
      send_beat(pack_char(8'h00, 1'b0, RADIX_AUTO));
   endtask

   task automatic test_directed();
      send_text("0xg", RADIX_AUTO);
      send_text(" -0XfF", RADIX_HEX);
      send_beat(pack_char(8'hFF, 1'b0, RADIX_AUTO));
      send_text("5", 6'd1);
      send_text("+z", 6'd37);
      send_text("a", 6'd63);
      // blank after the sign ends the number, the digit after it is ignored
      send_text("+ 3", RADIX_DEC);
      send_text("zZ9", RADIX_MAX);
      send_beat(pack_char(8'h00, 1'b0, RADIX_AUTO));
      send_text("017 ", RADIX_AUTO);
   endtask

   task automatic test_saturation_edge();
      send_text("18446744073709551615", RADIX_DEC);
      send_beat(pack_char(8'h00, 1'b0, RADIX_AUTO));
      send_text("-18446744073709551616", RADIX_DEC);
      send_beat(pack_char(8'h00, 1'b0, RADIX_AUTO));
   endtask

   // mostly well-formed numbers with random content, the rest raw bytes
   task automatic test_random(int unsigned target);
      int unsigned           sent;
      int unsigned           len;
      int unsigned           eff;
      int unsigned           pick;
      logic [RADIX_BITS-1:0] rdx;
      logic [7:0]            text[$];
      sent = 0;
      while (sent < target) begin
         if ($urandom_range(99) < 20) begin
            len = $urandom_range(6, 1);
            for (int i = 0; i < len; i++)
               send_beat(pack_char(8'($urandom_range(255)), (i == 0) && $urandom_range(1),
                                   RADIX_BITS'($urandom_range(63))));
            sent += len;
         end else begin
            text.delete();
            pick = $urandom_range(9);
            case (pick)
               0, 1, 2: rdx = RADIX_AUTO;
               3:       rdx = RADIX_HEX;
               4:       rdx = RADIX_DEC;
               5:       rdx = RADIX_OCT;
               6, 7:    rdx = RADIX_BITS'($urandom_range(36, 2));
               8:       rdx = $urandom_range(1) ? RADIX_MAX : RADIX_MIN;
               default: rdx = $urandom_range(1) ? 6'd1 : RADIX_BITS'($urandom_range(63, 37));
            endcase
            repeat ($urandom_range(2))
               text.push_back($urandom_range(1) ? CH_SPACE : 8'($urandom_range(CH_CR, CH_TAB)));
            case ($urandom_range(2))
               0: text.push_back(CH_PLUS);
               1: text.push_back(CH_MINUS);
               default: ;
            endcase
            eff = (rdx < RADIX_MIN || rdx > RADIX_MAX) ? 10 : rdx;
            if ((rdx == RADIX_AUTO || rdx == RADIX_HEX) && $urandom_range(99) < 40) begin
               text.push_back(CH_DIG0);
               text.push_back($urandom_range(1) ? CH_LOWER_X : CH_UPPER_X);
               eff = 16;
            end else if (rdx == RADIX_AUTO && $urandom_range(99) < 30) begin
               text.push_back(CH_DIG0);
               eff = 8;
            end
            if ($urandom_range(99) < 5) len = 0;
            else if ($urandom_range(99) < 25) len = $urandom_range(24, 1);
            else len = $urandom_range(6, 1);
            repeat (len) text.push_back(digit_char($urandom_range(eff - 1)));
            text.push_back($urandom_range(1) ? 8'h00 : 8'($urandom_range(255)));
            foreach (text[i])
               send_beat(pack_char(text[i], i == 0,
                                   i == 0 ? rdx : RADIX_BITS'($urandom_range(63))));
            sent += text.size();
            // trailing bytes, mostly ignored once the number has ended
            repeat ($urandom_range(2))
               send_beat(pack_char(8'($urandom_range(255)), 1'b0,
                                   RADIX_BITS'($urandom_range(63))));
         end
      end
   endtask

   // long receiver stall while the sender keeps offering, so the input backs up
   task automatic test_backpressure();
      hold_left = 400;
      test_random(30);
      wait_drained();
   endtask

   initial begin
      clear_parser();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 36;
      rcv_idle_pct  = 57;
      test_no_start();
      test_directed();
      test_saturation_edge();
      test_random(220);
      wait_drained();

      send_idle_pct = 57;
      rcv_idle_pct  = 36;
      test_random(220);
      wait_drained();

      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      test_random(230);
      test_backpressure();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("** unsigned_integer_text_parser_top: PASSED **");
      end else begin
         $display("** unsigned_integer_text_parser_top: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> sim.f
rtl/uitp_pkg.sv
rtl/uitp_front.sv
rtl/uitp_queue.sv
rtl/uitp_back.sv
rtl/unsigned_integer_text_parser_top.sv
sim/tb.sv
